/* rtl/procedural_sky_shader_unit_macros.svh */
// Assertion macros shared by the procedural sky shader RTL.
`ifndef PROCEDURAL_SKY_SHADER_UNIT_MACROS_SVH
`define PROCEDURAL_SKY_SHADER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define PSS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define PSS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define PSS_ASSERT_ALWAYS(name, cond, msg)
`define PSS_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

/* rtl/pss_pkg.sv */
// Package with types, constants and fixed-point helpers of the sky shader.
`default_nettype none

package pss_pkg;

    // One unsigned Q8.8 color channel and a packed RGB register.
    typedef logic [15:0] chan_t;
    typedef logic [47:0] rgb_word_t;
    typedef logic signed [15:0] q15_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SKY_COLOR      = 3'd0,
        CFG_SKYLINE_COLOR  = 3'd1,
        CFG_GROUND_COLOR   = 3'd2,
        CFG_SUN_GLOW_COLOR = 3'd3,
        CFG_GROUND_LEVEL   = 3'd4,
        CFG_SUN_DIR_X      = 3'd5,
        CFG_SUN_DIR_Y      = 3'd6,
        CFG_SUN_DIR_Z      = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned PIPE_DEPTH  = 7;

    // Fixed-point constants.
    localparam logic [15:0] ONE_Q15  = 16'h8000;
    localparam logic [15:0] HALF_Q15 = 16'h4000;
    localparam chan_t       CH_MAX   = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam rgb_word_t SKY_COLOR_RESET      = 48'd2199043375232;
    localparam rgb_word_t SKYLINE_COLOR_RESET  = 48'd2199056810496;
    localparam rgb_word_t GROUND_COLOR_RESET   = 48'd330713333773;
    localparam rgb_word_t SUN_GLOW_COLOR_RESET = 48'd7477672282624;
    localparam q15_t      GROUND_LEVEL_RESET   = -16'sd6554;
    localparam q15_t      SUN_DIR_X_RESET      = 16'sd26272;
    localparam q15_t      SUN_DIR_Y_RESET      = 16'sd8760;
    localparam q15_t      SUN_DIR_Z_RESET      = 16'sd17516;

    // Rounded Q1.15 square of a value in 0..1.0; the result stays in 0..1.0.
    function automatic logic [15:0] sq15(input logic [15:0] t);
        logic [32:0] acc;
        acc = 33'(t) * 33'(t) + 33'(HALF_Q15);
        return acc[30:15];
    endfunction

    // Rounded product of a Q8.8 channel and a Q1.15 factor in 0..1.0.
    function automatic chan_t mul15(input chan_t c, input logic [15:0] f);
        logic [32:0] acc;
        acc = 33'(c) * 33'(f) + 33'(HALF_Q15);
        return acc[30:15];
    endfunction

    // Rounded blend from a toward b by a Q1.15 weight w in 0..1.0.
    function automatic chan_t blend15(input chan_t a, input chan_t b, input logic [15:0] w);
        logic [32:0] acc;
        logic [15:0] wn;
        wn  = ONE_Q15 - w;
        acc = 33'(a) * 33'(wn) + 33'(b) * 33'(w) + 33'(HALF_Q15);
        return acc[30:15];
    endfunction

    // Extracts channel k (0 red, 1 green, 2 blue) of a packed color.
    function automatic chan_t chan_of(input rgb_word_t packed_rgb, input logic [1:0] k);
        return packed_rgb[16 * k +: 16];
    endfunction

endpackage

`default_nettype wire

/* rtl/pss_ray_if.sv */
// Stream interface that carries one ray direction per transfer.
`default_nettype none

interface pss_ray_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

/* rtl/pss_color_if.sv */
// Stream interface that carries one RGB color per transfer.
`default_nettype none

interface pss_color_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* rtl/procedural_sky_shader_unit.sv */
// Procedural sky shader: ray direction in, saturated RGB backdrop color out.
//
// The unit maps each unit ray direction (signed Q1.15) to a Q8.8 RGB color: ground color
// below the ground level, otherwise a sky-to-horizon blend plus a sun glow term. It is a
// seven-stage pipeline that accepts one ray per clock while results are taken and delivers
// each result from its last register stage; the depth is set by the chain of squarings (three
// for the horizon weight, two for the sun power) followed by the blend and glow
// multipliers and the final saturation stage. A stall on the color side freezes the whole
// pipeline, so a ray is still taken in any cycle in which the last stage is empty or its
// result is taken. Configuration writes take effect at once and are meant for idle time.
`default_nettype none

`include "procedural_sky_shader_unit_macros.svh"

module procedural_sky_shader_unit
    import pss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    pss_ray_if.sink                     ray,
    pss_color_if.source                 color
);

    // Configuration registers.
    rgb_word_t sky_color_reg;
    rgb_word_t skyline_color_reg;
    rgb_word_t ground_color_reg;
    rgb_word_t sun_glow_color_reg;
    q15_t      ground_level_reg;
    q15_t      sun_dir_x_reg;
    q15_t      sun_dir_y_reg;
    q15_t      sun_dir_z_reg;

    // Pipeline control.
    logic [PIPE_DEPTH-1:0] stage_vld_reg;
    logic [PIPE_DEPTH-1:0] stage_vld_next;
    logic                  adv;

    // Stage 1: dot-product terms, horizon base and ground test.
    logic signed [31:0] prod_x1_reg, prod_y1_reg, prod_z1_reg;
    logic signed [31:0] prod_x1_next, prod_y1_next, prod_z1_next;
    logic [15:0]        t1_reg, t1_next;
    q15_t               z1_reg;
    logic               below1_reg, below1_next;

    // Stage 2: dot product and first squaring of the weight.
    logic signed [33:0] d2_reg, d2_next;
    logic [15:0]        t2_reg, t2_next;
    q15_t               z2_reg;
    logic               below2_reg;

    // Stage 3: clamped sun factor and second squaring.
    logic [15:0] d15_3_reg, d15_3_next;
    logic [15:0] t3_reg, t3_next;
    q15_t        z3_reg;
    logic        below3_reg;

    // Stage 4: final weight and first sun squaring.
    logic [15:0] w4_reg, w4_next;
    logic [15:0] q4_reg, q4_next;
    q15_t        z4_reg;
    logic        below4_reg;

    // Stage 5: sun power and blend start colors.
    logic [15:0] w5_reg;
    logic [15:0] p5_reg, p5_next;
    chan_t       base5_reg [3];
    chan_t       base5_next [3];
    logic        below5_reg;

    // Stage 6: blended base and glow per channel.
    chan_t blend6_reg [3];
    chan_t blend6_next [3];
    chan_t glow6_reg [3];
    chan_t glow6_next [3];
    logic  below6_reg;

    // Stage 7: output register.
    chan_t out7_reg [3];
    chan_t out7_next [3];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sky_color_reg      <= SKY_COLOR_RESET;
            skyline_color_reg  <= SKYLINE_COLOR_RESET;
            ground_color_reg   <= GROUND_COLOR_RESET;
            sun_glow_color_reg <= SUN_GLOW_COLOR_RESET;
            ground_level_reg   <= GROUND_LEVEL_RESET;
            sun_dir_x_reg      <= SUN_DIR_X_RESET;
            sun_dir_y_reg      <= SUN_DIR_Y_RESET;
            sun_dir_z_reg      <= SUN_DIR_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SKY_COLOR:      sky_color_reg      <= cfg_data;
                CFG_SKYLINE_COLOR:  skyline_color_reg  <= cfg_data;
                CFG_GROUND_COLOR:   ground_color_reg   <= cfg_data;
                CFG_SUN_GLOW_COLOR: sun_glow_color_reg <= cfg_data;
                CFG_GROUND_LEVEL:   ground_level_reg   <= cfg_data[15:0];
                CFG_SUN_DIR_X:      sun_dir_x_reg      <= cfg_data[15:0];
                CFG_SUN_DIR_Y:      sun_dir_y_reg      <= cfg_data[15:0];
                CFG_SUN_DIR_Z:      sun_dir_z_reg      <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // The pipeline moves whenever the last stage is empty or its result transfers.
    assign adv            = !stage_vld_reg[PIPE_DEPTH-1] || color.ready;
    assign ray.ready      = adv;
    assign stage_vld_next = {stage_vld_reg[PIPE_DEPTH-2:0], ray.valid};

    // Stage 1 logic: sun products, 1 - |z| and the ground test.
    always_comb
    begin
        logic [15:0] az;
        az           = ray.dir_z[15] ? 16'(-ray.dir_z) : 16'(ray.dir_z);
        t1_next      = ONE_Q15 - az;
        below1_next  = ray.dir_z < ground_level_reg;
        prod_x1_next = sun_dir_x_reg * ray.dir_x;
        prod_y1_next = sun_dir_y_reg * ray.dir_y;
        prod_z1_next = sun_dir_z_reg * ray.dir_z;
    end

    // Stage 2 logic: dot product sum and first weight squaring.
    assign d2_next = 34'(prod_x1_reg) + 34'(prod_y1_reg) + 34'(prod_z1_reg);
    assign t2_next = sq15(t1_reg);

    // Stage 3 logic: round the dot product to Q1.15 and clamp to 0..1.0.
    always_comb
    begin
        logic signed [34:0] dr;
        logic [19:0]        sh;
        dr = 35'(d2_reg) + 35'(HALF_Q15);
        sh = dr[34:15];
        if (d2_reg <= 34'sd0)
        begin
            d15_3_next = 16'd0;
        end
        else if (sh > 20'(ONE_Q15))
        begin
            d15_3_next = ONE_Q15;
        end
        else
        begin
            d15_3_next = sh[15:0];
        end
        t3_next = sq15(t2_reg);
    end

    // Stage 4 logic: eighth power weight and sun square.
    assign w4_next = sq15(t3_reg);
    assign q4_next = sq15(d15_3_reg);

    // Stage 5 logic: sun fourth power and the blend start color.
    always_comb
    begin
        p5_next = sq15(q4_reg);
        for (int k = 0; k < 3; k++)
        begin
            if (!z4_reg[15])
            begin
                base5_next[k] = mul15(chan_of(sky_color_reg, 2'(k)), 16'(z4_reg));
            end
            else
            begin
                base5_next[k] = chan_of(ground_color_reg, 2'(k));
            end
        end
    end

    // Stage 6 logic: blend toward the skyline color and scale the glow.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            blend6_next[k] = blend15(base5_reg[k], chan_of(skyline_color_reg, 2'(k)), w5_reg);
            glow6_next[k]  = mul15(chan_of(sun_glow_color_reg, 2'(k)), p5_reg);
        end
    end

    // Stage 7 logic: add, saturate, or pass the ground color below the ground level.
    always_comb
    begin
        logic [16:0] sum;
        for (int k = 0; k < 3; k++)
        begin
            sum = 17'(blend6_reg[k]) + 17'(glow6_reg[k]);
            if (below6_reg)
            begin
                out7_next[k] = chan_of(ground_color_reg, 2'(k));
            end
            else if (sum[16])
            begin
                out7_next[k] = CH_MAX;
            end
            else
            begin
                out7_next[k] = sum[15:0];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
        end
        else if (adv)
        begin
            stage_vld_reg <= stage_vld_next;
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x1_reg <= prod_x1_next;
            prod_y1_reg <= prod_y1_next;
            prod_z1_reg <= prod_z1_next;
            t1_reg      <= t1_next;
            z1_reg      <= ray.dir_z;
            below1_reg  <= below1_next;

            d2_reg      <= d2_next;
            t2_reg      <= t2_next;
            z2_reg      <= z1_reg;
            below2_reg  <= below1_reg;

            d15_3_reg   <= d15_3_next;
            t3_reg      <= t3_next;
            z3_reg      <= z2_reg;
            below3_reg  <= below2_reg;

            w4_reg      <= w4_next;
            q4_reg      <= q4_next;
            z4_reg      <= z3_reg;
            below4_reg  <= below3_reg;

            w5_reg      <= w4_reg;
            p5_reg      <= p5_next;
            base5_reg   <= base5_next;
            below5_reg  <= below4_reg;

            blend6_reg  <= blend6_next;
            glow6_reg   <= glow6_next;
            below6_reg  <= below5_reg;

            out7_reg    <= out7_next;
        end
    end

    // Result channel.
    assign color.valid = stage_vld_reg[PIPE_DEPTH-1];
    assign color.red   = out7_reg[0];
    assign color.green = out7_reg[1];
    assign color.blue  = out7_reg[2];

    // The horizon weight never leaves the range 0..1.0.
    `PSS_ASSERT_ALWAYS(a_weight_range, !stage_vld_reg[3] || (w4_reg <= ONE_Q15), "weight above 1.0")

    // A ray facing away from the sun gets no glow factor.
    `PSS_ASSERT_NEXT(a_no_glow_behind, adv && stage_vld_reg[1] && (d2_reg <= 34'sd0), d15_3_reg == 16'd0, "sun factor not zero for a non-positive dot product")

    // A stall freezes every stage; checked on the valid bits and the red and blue results.
    `PSS_ASSERT_NEXT(a_stall_freeze, !adv, $stable(stage_vld_reg) && $stable(out7_reg[0]) && $stable(out7_reg[2]), "pipeline moved during a stall")

    // Below the ground level the ground color passes unchanged.
    `PSS_ASSERT_NEXT(a_ground_pass, adv && stage_vld_reg[5] && below6_reg, (color.red == ground_color_reg[15:0]) && (color.green == ground_color_reg[31:16]) && (color.blue == ground_color_reg[47:32]), "ground color not passed through")

endmodule

`default_nettype wire
